// File: hw/rtl/mtbs_pkg.sv
// Package for the MT19937 byte source: generator constants and sequencer states.
// No dependencies. Used by mersenne_twister_byte_source_unit.
package mtbs_pkg;

  localparam int unsigned MT_N     = 624;
  localparam int unsigned IDX_W    = 10;

  localparam logic [IDX_W-1:0] MT_LAST  = 10'd623;
  localparam logic [IDX_W:0]   MT_N_EXT = 11'd624;
  localparam logic [IDX_W:0]   MT_M_EXT = 11'd397;

  localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
  localparam logic [31:0] MT_UPPER     = 32'h8000_0000;
  localparam logic [31:0] MT_LOWER     = 32'h7fff_ffff;
  localparam logic [31:0] MT_MATRIX    = 32'd2567483615;
  localparam logic [31:0] MT_TEMPER_B  = 32'd2636928640;
  localparam logic [31:0] MT_TEMPER_C  = 32'd4022730752;

  localparam logic FUNC_SEED = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_SEED_MUL,
    ST_SEED_WR,
    ST_TW_PRE,
    ST_TW_LOAD,
    ST_TW_RD,
    ST_TW_WR,
    ST_DR_RD,
    ST_DR_TEMPER,
    ST_EMIT
  } mtbs_state_t;

endpackage

// File: hw/rtl/mtbs_ram.sv
// Generic simple RAM: one write port, two read ports, registered read data.
// No dependencies.
module mtbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hw/rtl/mersenne_twister_byte_source_unit.sv
// MT19937 byte source, top level. Uses mtbs_pkg and mtbs_ram (624 x 32 state memory).
// Reseed stores the seed word, then derives each further word with one shared
// 32x32 multiply. A draw reads and tempers one word into the output register;
// when the word index is zero, a twist first regenerates all 624 words in place.
// A draw before any seed returns a zero word with not_seeded set.
// One transaction at a time. Reset clears index, seeded flag, sequencer and output
// valid; memory is not cleared since it is only read after a seed has filled it.
module mersenne_twister_byte_source_unit (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        func,
  input  logic [31:0] seed_value,
  input  logic [2:0]  byte_count,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] random_word,
  output logic        not_seeded
);

  localparam int unsigned IW = mtbs_pkg::IDX_W;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtbs_pkg::MT_TEMPER_B);
    y = y ^ ((y << 15) & mtbs_pkg::MT_TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // sequencer and control
  mtbs_pkg::mtbs_state_t state, state_next;
  logic [IW-1:0] word_index;     // next word to temper
  logic          seeded;
  logic [IW-1:0] k;              // sweep counter for seed / twist
  logic [31:0]   prev;           // seed: previous word; twist: state[k]
  logic [31:0]   prod;           // registered multiplier output
  logic [2:0]    count;          // byte_count of the pending draw
  logic [31:0]   res_word;
  logic          res_ns;

  // memory ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [IW-1:0] ram_raddr_a;
  logic [IW-1:0] ram_raddr_b;
  logic [31:0]   ram_rdata_a;
  logic [31:0]   ram_rdata_b;

  logic          accept;
  logic          out_free;
  logic          k_last;
  logic [IW-1:0] k_plus1;        // (k + 1) mod 624
  logic [IW:0]   far_sum;
  logic [IW-1:0] k_far;          // (k + 397) mod 624
  logic [31:0]   seed_x;
  logic [31:0]   seed_word;
  logic [31:0]   tw_y;
  logic [31:0]   tw_v;
  logic [31:0]   tempered;
  logic [31:0]   masked;

  mtbs_ram #(
    .WIDTH(32),
    .DEPTH(mtbs_pkg::MT_N)
  ) u_state_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr_a(ram_raddr_a),
    .rdata_a(ram_rdata_a),
    .raddr_b(ram_raddr_b),
    .rdata_b(ram_rdata_b)
  );

  // index arithmetic
  assign k_last  = (k == mtbs_pkg::MT_LAST);
  assign k_plus1 = k_last ? '0 : k + 1'b1;
  assign far_sum = {1'b0, k} + mtbs_pkg::MT_M_EXT;
  assign k_far   = (far_sum >= mtbs_pkg::MT_N_EXT) ?
                   IW'(far_sum - mtbs_pkg::MT_N_EXT) : far_sum[IW-1:0];

  // seed recurrence: prod = MULT * (prev ^ prev>>30), then + k
  assign seed_x    = prev ^ (prev >> 30);
  assign seed_word = prod + {{(32-IW){1'b0}}, k};

  // twist of one word: prev = state[k], port a = state[k+1], port b = state[k+397]
  assign tw_y = (prev & mtbs_pkg::MT_UPPER) | (ram_rdata_a & mtbs_pkg::MT_LOWER);
  assign tw_v = ram_rdata_b ^ (tw_y >> 1) ^ (tw_y[0] ? mtbs_pkg::MT_MATRIX : '0);

  // draw: temper and keep the top count bytes (counts other than 1 to 3 keep the full word)
  assign tempered = temper(ram_rdata_a);
  always_comb begin
    unique case (count)
      3'd1:    masked = tempered & 32'hff00_0000;
      3'd2:    masked = tempered & 32'hffff_0000;
      3'd3:    masked = tempered & 32'hffff_ff00;
      default: masked = tempered;
    endcase
  end

  assign accept   = req_valid && !req_stall;
  assign out_free = !rsp_valid || !rsp_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtbs_pkg::ST_IDLE: begin
        if (req_valid) begin
          if (func == mtbs_pkg::FUNC_SEED) begin
            state_next = mtbs_pkg::ST_SEED_INIT;
          end else if (!seeded) begin
            state_next = mtbs_pkg::ST_EMIT;
          end else if (word_index == '0) begin
            state_next = mtbs_pkg::ST_TW_PRE;
          end else begin
            state_next = mtbs_pkg::ST_DR_RD;
          end
        end
      end
      mtbs_pkg::ST_SEED_INIT: state_next = mtbs_pkg::ST_SEED_MUL;
      mtbs_pkg::ST_SEED_MUL:  state_next = mtbs_pkg::ST_SEED_WR;
      mtbs_pkg::ST_SEED_WR:   state_next = k_last ? mtbs_pkg::ST_IDLE : mtbs_pkg::ST_SEED_MUL;
      mtbs_pkg::ST_TW_PRE:    state_next = mtbs_pkg::ST_TW_LOAD;
      mtbs_pkg::ST_TW_LOAD:   state_next = mtbs_pkg::ST_TW_RD;
      mtbs_pkg::ST_TW_RD:     state_next = mtbs_pkg::ST_TW_WR;
      mtbs_pkg::ST_TW_WR:     state_next = k_last ? mtbs_pkg::ST_DR_RD : mtbs_pkg::ST_TW_RD;
      mtbs_pkg::ST_DR_RD:     state_next = mtbs_pkg::ST_DR_TEMPER;
      mtbs_pkg::ST_DR_TEMPER: state_next = mtbs_pkg::ST_EMIT;
      mtbs_pkg::ST_EMIT:      state_next = out_free ? mtbs_pkg::ST_IDLE : mtbs_pkg::ST_EMIT;
      default:                state_next = mtbs_pkg::ST_IDLE;
    endcase
  end

  // state-decoded outputs: request stall and memory controls
  always_comb begin
    req_stall   = 1'b1;
    ram_we      = 1'b0;
    ram_waddr   = k;
    ram_wdata   = tw_v;
    ram_raddr_a = k_plus1;
    ram_raddr_b = k_far;
    unique case (state)
      mtbs_pkg::ST_IDLE: req_stall = 1'b0;
      mtbs_pkg::ST_SEED_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = prev;
      end
      mtbs_pkg::ST_SEED_WR: begin
        ram_we    = 1'b1;
        ram_wdata = seed_word;
      end
      mtbs_pkg::ST_TW_PRE: ram_raddr_a = '0;
      mtbs_pkg::ST_TW_WR:  ram_we = 1'b1;
      mtbs_pkg::ST_DR_RD:  ram_raddr_a = word_index;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtbs_pkg::ST_IDLE;
      word_index <= '0;
      seeded     <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mtbs_pkg::ST_SEED_WR && k_last) begin
        seeded     <= 1'b1;
        word_index <= '0;
      end
      if (state == mtbs_pkg::ST_DR_TEMPER) begin
        word_index <= (word_index == mtbs_pkg::MT_LAST) ? '0 : word_index + 1'b1;
      end
      if (state == mtbs_pkg::ST_EMIT && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      prev     <= seed_value;
      count    <= byte_count;
      res_word <= '0;
      res_ns   <= 1'b1;
    end
    unique case (state)
      mtbs_pkg::ST_SEED_INIT: k <= IW'(1);
      mtbs_pkg::ST_SEED_MUL:  prod <= 32'(seed_x * mtbs_pkg::MT_INIT_MULT);
      mtbs_pkg::ST_SEED_WR: begin
        prev <= seed_word;
        k    <= k_plus1;
      end
      mtbs_pkg::ST_TW_PRE:  k <= '0;
      mtbs_pkg::ST_TW_LOAD: prev <= ram_rdata_a;
      mtbs_pkg::ST_TW_WR: begin
        prev <= ram_rdata_a;   // old state[k+1] becomes the next step's state[k]
        k    <= k_plus1;
      end
      mtbs_pkg::ST_DR_TEMPER: begin
        res_word <= masked;
        res_ns   <= 1'b0;
      end
      default: ;
    endcase
    if (state == mtbs_pkg::ST_EMIT && out_free) begin
      random_word <= res_word;
      not_seeded  <= res_ns;
    end
  end

  // checks
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    word_index <= mtbs_pkg::MT_LAST)
    else $error("word index out of range");

  a_unseeded_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && not_seeded |-> random_word == '0)
    else $error("unseeded draw returned nonzero word");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != mtbs_pkg::ST_IDLE)
    else $error("transaction accepted but sequencer stayed idle");

  a_no_twist_unseeded: assert property (@(posedge clk) disable iff (rst)
    !seeded |-> !(state == mtbs_pkg::ST_TW_RD || state == mtbs_pkg::ST_TW_WR))
    else $error("twist started before any seed");

endmodule

// File: test/tb_top.sv
// Testbench for mersenne_twister_byte_source_unit: directed table, then random transactions.
// Depends on mtbs_pkg and the unit's RTL. Expected words come from a predictor kept in this
// file, which mirrors the MT19937 seed, twist and tempering steps.
module tb_top;

  // Upper bound on a correct run: every transaction a full reseed or twist
  // plus the longest sender gap and receiver stall, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  // Longest single operation in the unit (reseed or draw with twist), used for the drain.
  localparam int unsigned DRAIN_CYCLES = 1400;
  localparam int unsigned MAX_GAP = 17;
  localparam int unsigned LONG_RUN_DRAWS = 300;
  localparam int unsigned MIXED_ITEMS = 75;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic        func = mtbs_pkg::FUNC_DRAW;
  logic [31:0] seed_value = '0;
  logic [2:0]  byte_count = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [31:0] random_word;
  logic        not_seeded;

  mersenne_twister_byte_source_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .func       (func),
    .seed_value (seed_value),
    .byte_count (byte_count),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .random_word(random_word),
    .not_seeded (not_seeded)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Generator predictor: own copy of the 624-word table, read position and seed flag.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] word;
    logic        unseeded;
  } draw_result_t;

  logic [31:0]  gen_table [mtbs_pkg::MT_N];
  int unsigned  gen_pos = 0;
  bit           gen_seeded = 1'b0;
  draw_result_t pending_draws[$];  // expected draw results, oldest first
  int unsigned  error_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  quiet_run[2] = '{0, 0};  // per side: remaining transactions with no gap

  // Initialization recurrence: each word from the previous one, plus its index.
  function automatic void load_seed(input logic [31:0] seed);
    logic [31:0] prev;
    gen_table[0] = seed;
    for (int k = 1; k < mtbs_pkg::MT_N; k++) begin
      prev = gen_table[k-1];
      gen_table[k] = mtbs_pkg::MT_INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
    end
    gen_pos = 0;
    gen_seeded = 1'b1;
  endfunction

  // In-place regeneration of all 624 words; later words see already updated early ones.
  function automatic void regenerate_table();
    logic [31:0] mixed;
    logic [31:0] nxt;
    for (int k = 0; k < mtbs_pkg::MT_N; k++) begin
      mixed = (gen_table[k] & mtbs_pkg::MT_UPPER) |
              (gen_table[(k + 1) % mtbs_pkg::MT_N] & mtbs_pkg::MT_LOWER);
      nxt = gen_table[(k + int'(mtbs_pkg::MT_M_EXT)) % mtbs_pkg::MT_N] ^ (mixed >> 1);
      if (mixed[0])
        nxt ^= mtbs_pkg::MT_MATRIX;
      gen_table[k] = nxt;
    end
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] raw);
    logic [31:0] y;
    y = raw;
    y ^= y >> 11;
    y ^= (y << 7) & mtbs_pkg::MT_TEMPER_B;
    y ^= (y << 15) & mtbs_pkg::MT_TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  function automatic draw_result_t predict_draw(input logic [2:0] count);
    draw_result_t res;
    logic [31:0]  keep;
    res = '0;
    if (!gen_seeded) begin
      // draw before any seed: zero word, flag set, nothing advances
      res.unseeded = 1'b1;
      return res;
    end
    if (gen_pos == 0)
      regenerate_table();
    res.word = temper(gen_table[gen_pos]);
    gen_pos = (gen_pos + 1) % mtbs_pkg::MT_N;
    case (count)
      3'd1: keep = 32'hff00_0000;
      3'd2: keep = 32'hffff_0000;
      3'd3: keep = 32'hffff_ff00;
      default: keep = 32'hffff_ffff;  // 0 and 4..7 behave as a full word
    endcase
    res.word &= keep;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly random gaps bounded by MAX_GAP, with occasional quiet stretches.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap(input int side);
    if (quiet_run[side] != 0) begin
      quiet_run[side]--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0)
      quiet_run[side] = $urandom_range(8, 40);
    return $urandom_range(0, MAX_GAP);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("MISMATCH @%0t %s: got %h expected %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Request side. Called right after a rising edge; returns right after the edge at which
  // the transaction was accepted. req_valid is only lowered when a gap follows, so it is
  // never lowered and raised in the same step.
  // ---------------------------------------------------------------------------
  task automatic issue_request(input logic f, input logic [31:0] s, input logic [2:0] c,
                               input bit fixed, input draw_result_t literal);
    int unsigned gap;
    draw_result_t res;
    gap = pick_gap(0);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    func       <= f;
    seed_value <= s;
    byte_count <= c;
    do
      @(posedge clk);
    while (req_stall !== 1'b0);
    // accepted at this edge: advance the predictor in transaction order
    if (f == mtbs_pkg::FUNC_SEED) begin
      load_seed(s);
    end else begin
      res = predict_draw(c);
      pending_draws.push_back(fixed ? literal : res);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random stall before each result, field-by-field compare on accept.
  // Outputs are read right after the edge, so they are the values the edge sampled.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned  gap;
    draw_result_t want;
    forever begin
      gap = pick_gap(1);
      if (gap != 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do
        @(posedge clk);
      while (rsp_valid !== 1'b1);
      if (pending_draws.size() == 0) begin
        report_mismatch("result with nothing outstanding", random_word, '0);
      end else begin
        want = pending_draws.pop_front();
        if (random_word !== want.word)
          report_mismatch("random_word", random_word, want.word);
        if (not_seeded !== want.unseeded)
          report_mismatch("not_seeded", 32'(not_seeded), 32'(want.unseeded));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. A row with fixed set carries its expected word; the rest use the
  // predictor. Known MT19937 outputs for seed 5489 serve as an independent anchor.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic        func_sel;
    logic [31:0] seed;
    logic [2:0]  count;
    bit          fixed;
    logic [31:0] want_word;
    logic        want_flag;
  } stim_row_t;

  stim_row_t directed_rows[$];

  function automatic void add_row(input logic f, input logic [31:0] s, input logic [2:0] c,
                                  input bit fixed = 1'b0, input logic [31:0] w = '0,
                                  input logic fl = 1'b0);
    stim_row_t r;
    r.func_sel  = f;
    r.seed      = s;
    r.count     = c;
    r.fixed     = fixed;
    r.want_word = w;
    r.want_flag = fl;
    directed_rows.push_back(r);
  endfunction

  initial begin
    draw_result_t lit;
    logic [31:0]  s;
    logic         f;

    // draws before any seed: zero word with the flag, count encodings 4, 0 and 7
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0000_0000, 3'd4, 1'b1, 32'h0, 1'b1);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0000_0000, 3'd0, 1'b1, 32'h0, 1'b1);
    add_row(mtbs_pkg::FUNC_DRAW, 32'hffff_ffff, 3'd7, 1'b1, 32'h0, 1'b1);
    // standard default seed: first four words, each with a different byte count
    add_row(mtbs_pkg::FUNC_SEED, 32'd5489, 3'd0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd4, 1'b1, 32'hd091_bb5c, 1'b0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd1, 1'b1, 32'h2200_0000, 1'b0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd2, 1'b1, 32'he7e1_0000, 1'b0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd3, 1'b1, 32'hd5c3_1f00, 1'b0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'hffff_ffff, 3'd0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd5);
    // reseed in the middle of a sequence, all-zero seed
    add_row(mtbs_pkg::FUNC_SEED, 32'h0000_0000, 3'd7);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd6);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd7);
    // all-ones seed, every partial width
    add_row(mtbs_pkg::FUNC_SEED, 32'hffff_ffff, 3'd4);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd1);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd2);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd3);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd4);
    // back-to-back reseeds: only the second should count
    add_row(mtbs_pkg::FUNC_SEED, 32'h8000_0000, 3'd0);
    add_row(mtbs_pkg::FUNC_SEED, 32'h0000_0001, 3'd0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd4);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h0, 3'd0);
    add_row(mtbs_pkg::FUNC_SEED, 32'h7fff_ffff, 3'd0);
    add_row(mtbs_pkg::FUNC_DRAW, 32'h5555_aaaa, 3'd4);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      lit.word     = directed_rows[i].want_word;
      lit.unseeded = directed_rows[i].want_flag;
      issue_request(directed_rows[i].func_sel, directed_rows[i].seed, directed_rows[i].count,
                    directed_rows[i].fixed, lit);
    end

    // Long well-formed run: one seed, then a long stretch of draws from one sequence.
    lit = '0;
    s = ($urandom_range(0, 3) == 0) ? 32'hffff_ffff : $urandom;
    issue_request(mtbs_pkg::FUNC_SEED, s, 3'($urandom_range(0, 7)), 1'b0, lit);
    for (int n = 0; n < LONG_RUN_DRAWS; n++)
      issue_request(mtbs_pkg::FUNC_DRAW, $urandom, 3'($urandom_range(0, 7)), 1'b0, lit);

    // Mixed traffic: frequent reseeds mid-sequence, random seeds and count encodings.
    for (int n = 0; n < MIXED_ITEMS; n++) begin
      f = ($urandom_range(0, 5) == 0) ? mtbs_pkg::FUNC_SEED : mtbs_pkg::FUNC_DRAW;
      issue_request(f, $urandom, 3'($urandom_range(0, 7)), 1'b0, lit);
    end
    req_valid <= 1'b0;

    // Drain: wait for every outstanding draw, then watch for stray results.
    while (pending_draws.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_draws.size() != 0)
      report_mismatch("draw results never delivered", '0, 32'(pending_draws.size()));

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
